FILE: design/lsag_pkg.sv
package lsag_pkg;

    // Field widths
    localparam int Y_W       = 16;
    localparam int TIME_W    = 8;
    localparam int GCODE_W   = 2;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Datapath widths
    localparam int GAINV_W   = 10;              // largest gain value 640
    localparam int SPAN_W    = TIME_W + 1;      // 256 - code, up to 256
    localparam int FACTOR_W  = 18;              // factors up to 163840
    localparam int NUM_W     = FACTOR_W + Y_W;  // old factor times target
    localparam int Q_W       = FACTOR_W;        // quotient bits kept
    localparam int DIV_STEPS = Q_W;
    localparam int X_W       = 11;              // scaled factor, up to 1280
    localparam int RECIP_W   = 16;
    localparam int RECIP_SH  = 18;
    localparam int PROD_W    = X_W + RECIP_W;
    localparam int QUOT_W    = PROD_W - RECIP_SH;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HYST     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TIME = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0]  TARGET_RST   = 16'h7FFF;
    localparam logic [CFG_W-1:0]  HYST_RST     = 16'h3FFF;
    localparam logic [TIME_W-1:0] MIN_TIME_RST = 8'd180;

    // Gain codes
    localparam logic [GCODE_W-1:0] GAIN_X10  = 2'd0;
    localparam logic [GCODE_W-1:0] GAIN_X36  = 2'd1;
    localparam logic [GCODE_W-1:0] GAIN_X160 = 2'd2;
    localparam logic [GCODE_W-1:0] GAIN_X640 = 2'd3;

    localparam logic [FACTOR_W-1:0] FACTOR_MAX = 18'd163840;
    localparam logic [FACTOR_W-1:0] RANGE0_MAX = 18'd35;
    localparam logic [FACTOR_W-1:0] RANGE1_MAX = 18'd159;
    localparam logic [FACTOR_W-1:0] RANGE2_MAX = 18'd639;

    // Reciprocals scaled by 2^RECIP_SH: x/5 exact for x < 65536, x/9 for x < 32768
    localparam logic [RECIP_W-1:0] RECIP5 = 16'd52429;
    localparam logic [RECIP_W-1:0] RECIP9 = 16'd29128;

    typedef struct packed {
        logic [TIME_W-1:0]  int_time;
        logic [GCODE_W-1:0] gain_code;
        logic               adj;
    } t_pass;

    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [Y_W-1:0]   y;
        logic             sat;
        t_pass            pass;
    } t_front;

    typedef struct packed {
        logic [Q_W-1:0] quot;
        logic           sat;
        t_pass          pass;
    } t_quot;

    typedef struct packed {
        logic [TIME_W-1:0]  new_int_time;
        logic [GCODE_W-1:0] new_gain_code;
        logic               adjusted;
    } t_result;

    function automatic logic [GAINV_W-1:0] gain_of(input logic [GCODE_W-1:0] code);
        logic [GAINV_W-1:0] g;
        case (code)
            GAIN_X10:  g = 10'd10;
            GAIN_X36:  g = 10'd36;
            GAIN_X160: g = 10'd160;
            GAIN_X640: g = 10'd640;
            default:   g = 10'd10;
        endcase
        return g;
    endfunction

endpackage

FILE: design/lsag_in_if.sv
interface lsag_in_if
    import lsag_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [Y_W-1:0]     light_y;
    logic [TIME_W-1:0]  int_time;
    logic [GCODE_W-1:0] gain_code;

    modport source (output valid, output light_y, output int_time, output gain_code,
                    input ready);
    modport sink   (input valid, input light_y, input int_time, input gain_code,
                    output ready);
endinterface

FILE: design/lsag_out_if.sv
interface lsag_out_if
    import lsag_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [TIME_W-1:0]  new_int_time;
    logic [GCODE_W-1:0] new_gain_code;
    logic               adjusted;

    modport source (output valid, output new_int_time, output new_gain_code,
                    output adjusted, input ready);
    modport sink   (input valid, input new_int_time, input new_gain_code,
                    input adjusted, output ready);
endinterface

FILE: design/lsag_front.sv
module lsag_front
    import lsag_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  logic [Y_W-1:0]     i_light_y,
    input  logic [TIME_W-1:0]  i_int_time,
    input  logic [GCODE_W-1:0] i_gain_code,
    output logic               o_rdy,
    input  logic [CFG_W-1:0]   i_target,
    input  logic [CFG_W-1:0]   i_hyst,
    output logic               o_vld,
    output t_front             o_data,
    input  logic               i_rdy
);
    typedef struct packed {
        logic [FACTOR_W-1:0] old;
        logic [Y_W-1:0]      y;
        t_pass               pass;
    } t_s1;

    logic               r_vld1, r_vld2;
    t_s1                r_s1, n_s1;
    t_front             r_s2, n_s2;
    logic               w_ld1, w_ld2;
    logic [Y_W-1:0]     w_dev;
    logic [SPAN_W-1:0]  w_span;

    assign w_ld2 = !r_vld2 || i_rdy;
    assign w_ld1 = !r_vld1 || w_ld2;
    assign o_rdy = w_ld1;

    // Stage 1: band test and old gain factor
    always_comb begin
        w_dev  = (i_light_y >= i_target) ? (i_light_y - i_target) : (i_target - i_light_y);
        w_span = SPAN_W'(9'd256) - {1'b0, i_int_time};
        n_s1.old = {{(FACTOR_W-SPAN_W){1'b0}}, w_span}
                 * {{(FACTOR_W-GAINV_W){1'b0}}, gain_of(i_gain_code)};
        n_s1.y              = i_light_y;
        n_s1.pass.int_time  = i_int_time;
        n_s1.pass.gain_code = i_gain_code;
        n_s1.pass.adj       = (w_dev > i_hyst);
    end

    // Stage 2: scale by target
    always_comb begin
        n_s2.num  = {{(NUM_W-FACTOR_W){1'b0}}, r_s1.old} * {{(NUM_W-CFG_W){1'b0}}, i_target};
        n_s2.y    = r_s1.y;
        n_s2.sat  = (r_s1.y == '0);
        n_s2.pass = r_s1.pass;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
        end else begin
            if (w_ld1) r_vld1 <= i_vld;
            if (w_ld2) r_vld2 <= r_vld1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld1 && i_vld) r_s1 <= n_s1;
        if (w_ld2 && r_vld1) r_s2 <= n_s2;
    end

    assign o_vld  = r_vld2;
    assign o_data = r_s2;
endmodule

FILE: design/lsag_div.sv
module lsag_div
    import lsag_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_vld,
    input  t_front i_data,
    output logic   o_rdy,
    output logic   o_vld,
    output t_quot  o_data,
    input  logic   i_rdy
);
    typedef struct packed {
        logic [Y_W-1:0] rem;
        logic [Q_W-1:0] sh;     // dividend bits shift out the top, quotient bits in
        logic [Y_W-1:0] y;
        logic           sat;
        t_pass          pass;
    } t_stg;

    logic r_vld [DIV_STEPS];
    t_stg r_stg [DIV_STEPS];
    logic w_ld  [DIV_STEPS];
    logic w_dn  [DIV_STEPS];
    logic w_vin [DIV_STEPS];
    t_stg w_din [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        t_stg           n_stg;
        logic [Y_W:0]   w_a;
        logic           w_ge;

        if (k == 0) begin : g_first
            assign w_vin[k]       = i_vld;
            assign w_din[k].rem   = i_data.num[NUM_W-1 -: Y_W];
            assign w_din[k].sh    = i_data.num[Q_W-1:0];
            assign w_din[k].y     = i_data.y;
            // quotient would not fit in Q_W bits: saturate
            assign w_din[k].sat   = i_data.sat || (i_data.num[NUM_W-1 -: Y_W] >= i_data.y);
            assign w_din[k].pass  = i_data.pass;
        end else begin : g_next
            assign w_vin[k] = r_vld[k-1];
            assign w_din[k] = r_stg[k-1];
        end

        if (k == DIV_STEPS - 1) begin : g_last
            assign w_dn[k] = i_rdy;
        end else begin : g_mid
            assign w_dn[k] = w_ld[k+1];
        end

        assign w_ld[k] = !r_vld[k] || w_dn[k];

        // One restoring step: one quotient bit
        always_comb begin
            w_a  = {w_din[k].rem, w_din[k].sh[Q_W-1]};
            w_ge = (w_a >= {1'b0, w_din[k].y});
            n_stg      = w_din[k];
            n_stg.rem  = w_ge ? Y_W'(w_a - {1'b0, w_din[k].y}) : w_a[Y_W-1:0];
            n_stg.sh   = {w_din[k].sh[Q_W-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (w_ld[k]) begin
                r_vld[k] <= w_vin[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ld[k] && w_vin[k]) r_stg[k] <= n_stg;
        end
    end

    assign o_rdy       = w_ld[0];
    assign o_vld       = r_vld[DIV_STEPS-1];
    assign o_data.quot = r_stg[DIV_STEPS-1].sh;
    assign o_data.sat  = r_stg[DIV_STEPS-1].sat;
    assign o_data.pass = r_stg[DIV_STEPS-1].pass;
endmodule

FILE: design/lsag_back.sv
module lsag_back
    import lsag_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_vld,
    input  t_quot             i_data,
    output logic              o_rdy,
    input  logic [TIME_W-1:0] i_min_time,
    output logic              o_vld,
    output t_result           o_data,
    input  logic              i_rdy
);
    typedef struct packed {
        logic [X_W-1:0]     x;
        logic [RECIP_W-1:0] recip;
        logic [GCODE_W-1:0] code;
        t_pass              pass;
    } t_sa;

    typedef struct packed {
        logic [PROD_W-1:0]  prod;
        logic [GCODE_W-1:0] code;
        t_pass              pass;
    } t_sb;

    logic                r_vld_a, r_vld_b, r_vld_c;
    t_sa                 r_sa, n_sa;
    t_sb                 r_sb, n_sb;
    t_result             r_sc, n_sc;
    logic                w_ld_a, w_ld_b, w_ld_c;
    logic [FACTOR_W-1:0] w_f;
    logic [QUOT_W-1:0]   w_quot;
    logic [QUOT_W-1:0]   w_tc_full;
    logic [TIME_W-1:0]   w_tc;

    assign w_ld_c = !r_vld_c || i_rdy;
    assign w_ld_b = !r_vld_b || w_ld_c;
    assign w_ld_a = !r_vld_a || w_ld_b;
    assign o_rdy  = w_ld_a;

    // Stage A: pick range; split gain into power of two times 5 or 9
    always_comb begin
        // clamp quotients above the saturation limit as well
        w_f       = (i_data.sat || (i_data.quot > FACTOR_MAX)) ? FACTOR_MAX : i_data.quot;
        n_sa.pass = i_data.pass;
        if (w_f <= RANGE0_MAX)      n_sa.code = GAIN_X10;
        else if (w_f <= RANGE1_MAX) n_sa.code = GAIN_X36;
        else if (w_f <= RANGE2_MAX) n_sa.code = GAIN_X160;
        else                        n_sa.code = GAIN_X640;
        case (n_sa.code)
            GAIN_X10: begin
                n_sa.x     = X_W'(w_f >> 1);
                n_sa.recip = RECIP5;
            end
            GAIN_X36: begin
                n_sa.x     = X_W'(w_f >> 2);
                n_sa.recip = RECIP9;
            end
            GAIN_X160: begin
                n_sa.x     = X_W'(w_f >> 5);
                n_sa.recip = RECIP5;
            end
            default: begin
                n_sa.x     = X_W'(w_f >> 7);
                n_sa.recip = RECIP5;
            end
        endcase
    end

    // Stage B: reciprocal multiply
    always_comb begin
        n_sb.prod = {{(PROD_W-X_W){1'b0}}, r_sa.x} * {{(PROD_W-RECIP_W){1'b0}}, r_sa.recip};
        n_sb.code = r_sa.code;
        n_sb.pass = r_sa.pass;
    end

    // Stage C: time code, wrap, clamp, or pass codes through
    always_comb begin
        w_quot    = r_sb.prod[PROD_W-1 -: QUOT_W];
        w_tc_full = QUOT_W'(9'd256) - w_quot;
        w_tc      = w_tc_full[TIME_W-1:0];
        if (w_tc < i_min_time) w_tc = i_min_time;
        if (r_sb.pass.adj) begin
            n_sc.new_int_time  = w_tc;
            n_sc.new_gain_code = r_sb.code;
        end else begin
            n_sc.new_int_time  = r_sb.pass.int_time;
            n_sc.new_gain_code = r_sb.pass.gain_code;
        end
        n_sc.adjusted = r_sb.pass.adj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
        end else begin
            if (w_ld_a) r_vld_a <= i_vld;
            if (w_ld_b) r_vld_b <= r_vld_a;
            if (w_ld_c) r_vld_c <= r_vld_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld_a && i_vld)   r_sa <= n_sa;
        if (w_ld_b && r_vld_a) r_sb <= n_sb;
        if (w_ld_c && r_vld_b) r_sc <= n_sc;
    end

    assign o_vld  = r_vld_c;
    assign o_data = r_sc;
endmodule

FILE: design/light_sensor_auto_gain.sv
// Channel    Dir  Fields                                      Handshake
// i_sample   in   light_y[16] int_time[8] gain_code[2]        valid/ready
// o_result   out  new_int_time[8] new_gain_code[2] adjusted   valid/ready
// i_cfg_*    in   idx[2] data[16]: 0 target, 1 hyst, 2 min    write enable only
//
// One item per cycle sustained while o_result is not stalled; 23 register stages:
// two front stages (band test, factor products), 18 divider steps at one quotient
// bit each, three back stages (range pick, reciprocal multiply, clamp).
// Synchronous active-low reset clears all valid bits and loads register defaults.
// Every stage holds its item under stall and takes a new one as soon as it empties;
// ready ripples back combinationally, so the input stalls only when every stage is full.
module light_sensor_auto_gain
    import lsag_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lsag_in_if.sink              i_sample,
    lsag_out_if.source           o_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    logic [CFG_W-1:0]  r_target;
    logic [CFG_W-1:0]  r_hyst;
    logic [TIME_W-1:0] r_min_time;

    logic    w_front_vld, w_front_rdy;
    t_front  w_front;
    logic    w_div_vld, w_div_rdy;
    t_quot   w_quot;
    logic    w_back_rdy;
    t_result w_result;

    // Configuration registers; writes to unused indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target   <= TARGET_RST;
            r_hyst     <= HYST_RST;
            r_min_time <= MIN_TIME_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_TARGET:   r_target   <= i_cfg_data;
                REG_HYST:     r_hyst     <= i_cfg_data;
                REG_MIN_TIME: r_min_time <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    // Band test and wide product target * old factor
    lsag_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_vld       (i_sample.valid),
        .i_light_y   (i_sample.light_y),
        .i_int_time  (i_sample.int_time),
        .i_gain_code (i_sample.gain_code),
        .o_rdy       (i_sample.ready),
        .i_target    (r_target),
        .i_hyst      (r_hyst),
        .o_vld       (w_front_vld),
        .o_data      (w_front),
        .i_rdy       (w_front_rdy)
    );

    // Divide by light_y, saturating on zero reading or quotient overflow
    lsag_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_front_vld),
        .i_data  (w_front),
        .o_rdy   (w_front_rdy),
        .o_vld   (w_div_vld),
        .o_data  (w_quot),
        .i_rdy   (w_div_rdy)
    );

    // New gain range and integration time code; holds the result register
    lsag_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (w_div_vld),
        .i_data     (w_quot),
        .o_rdy      (w_back_rdy),
        .i_min_time (r_min_time),
        .o_vld      (o_result.valid),
        .o_data     (w_result),
        .i_rdy      (o_result.ready)
    );

    assign w_div_rdy              = w_back_rdy;
    assign o_result.new_int_time  = w_result.new_int_time;
    assign o_result.new_gain_code = w_result.new_gain_code;
    assign o_result.adjusted      = w_result.adjusted;

    // Input back-pressure only ever comes from a stalled, full output
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_sample.ready |-> (o_result.valid && !o_result.ready))
        else $error("input stalled without output stall");

    // No result leaves right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result.valid)
        else $error("result valid right after reset");
endmodule
